>>> rtl/rbs_pkg.sv
// Shared types, opcodes and constants of the robot bytecode sequencer.
package rbs_pkg;

	localparam int ADDR_BITS  = 16;
	localparam int RSP_ADDR_W = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_WAIT_UNIT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_TURN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_TURN  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TURN_DUTY  = 2'd3;

	localparam logic [7:0]  RST_WAIT_UNIT  = 8'd25;
	localparam logic [15:0] RST_RIGHT_TURN = 16'd1000;
	localparam logic [15:0] RST_LEFT_TURN  = 16'd1200;
	localparam logic [6:0]  RST_TURN_DUTY  = 7'd100;

	localparam logic [7:0] OP_START      = 8'h01;
	localparam logic [7:0] OP_WAIT       = 8'h02;
	localparam logic [7:0] OP_LED_ON     = 8'h44;
	localparam logic [7:0] OP_LED_OFF    = 8'h45;
	localparam logic [7:0] OP_TONE       = 8'h48;
	localparam logic [7:0] OP_TONE_OFF   = 8'h09;
	localparam logic [7:0] OP_STOP       = 8'h60;
	localparam logic [7:0] OP_STOP_ALT   = 8'h61;
	localparam logic [7:0] OP_FWD        = 8'h62;
	localparam logic [7:0] OP_REV        = 8'h63;
	localparam logic [7:0] OP_RIGHT      = 8'h64;
	localparam logic [7:0] OP_LEFT       = 8'h65;
	localparam logic [7:0] OP_LOOP_BEGIN = 8'hC0;
	localparam logic [7:0] OP_LOOP_END   = 8'hC1;
	localparam logic [7:0] OP_END        = 8'hFF;

	localparam logic [6:0] DUTY_SCALE = 7'd100;

	typedef enum logic [3:0] {
		ACT_NONE     = 4'd0,
		ACT_WAIT     = 4'd1,
		ACT_LED_ON   = 4'd2,
		ACT_LED_OFF  = 4'd3,
		ACT_TONE     = 4'd4,
		ACT_TONE_OFF = 4'd5,
		ACT_STOP     = 4'd6,
		ACT_FWD      = 4'd7,
		ACT_REV      = 4'd8,
		ACT_RIGHT    = 4'd9,
		ACT_LEFT     = 4'd10,
		ACT_END      = 4'd11
	} action_t;

	typedef struct packed {
		logic [7:0] opcode;
		logic [7:0] operand;
	} cmd_t;

	typedef struct packed {
		action_t               action;
		logic [7:0]            argument;
		logic [15:0]           duration_ms;
		logic [RSP_ADDR_W-1:0] next_address;
		logic                  finished;
	} rsp_t;

	typedef struct packed {
		logic [7:0]  wait_unit_ms;
		logic [15:0] right_turn_ms;
		logic [15:0] left_turn_ms;
		logic [6:0]  turn_duty;
	} cfg_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0] pc;
		logic                 running;
		logic                 in_loop;
		logic [ADDR_BITS-1:0] loop_start;
		logic [7:0]           loop_remaining;
		logic                 halted;
	} state_t;

endpackage

>>> rtl/rbs_cfg.sv
// Configuration register file of the robot bytecode sequencer.
module rbs_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rbs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rbs_pkg::CFG_DATA_W-1:0] cfg_data,
	output rbs_pkg::cfg_t                 cfg
);
	import rbs_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wait_unit_ms  <= RST_WAIT_UNIT;
			cfg_q.right_turn_ms <= RST_RIGHT_TURN;
			cfg_q.left_turn_ms  <= RST_LEFT_TURN;
			cfg_q.turn_duty     <= RST_TURN_DUTY;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WAIT_UNIT:  cfg_q.wait_unit_ms  <= cfg_data[7:0];
				REG_RIGHT_TURN: cfg_q.right_turn_ms <= cfg_data[15:0];
				REG_LEFT_TURN:  cfg_q.left_turn_ms  <= cfg_data[15:0];
				REG_TURN_DUTY:  cfg_q.turn_duty     <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/rbs_exec.sv
// Instruction decode and next-state logic of the robot bytecode sequencer.
module rbs_exec (
	input  rbs_pkg::cmd_t   cmd,
	input  rbs_pkg::state_t st,
	input  rbs_pkg::cfg_t   cfg,
	output rbs_pkg::rsp_t   rsp,
	output rbs_pkg::state_t st_nxt
);
	import rbs_pkg::*;

	logic [ADDR_BITS-1:0] pc_inc1;
	logic [ADDR_BITS-1:0] pc_inc2;
	logic [ADDR_BITS-1:0] nxt;
	logic [14:0]          duty_prod;
	logic [15:0]          duty_sum;
	logic [7:0]           duty;
	logic [15:0]          wait_ms;
	action_t              act;
	logic [7:0]           arg;
	logic [15:0]          dur;

	assign pc_inc1 = st.pc + ADDR_BITS'(1);
	assign pc_inc2 = st.pc + ADDR_BITS'(2);

	// operand * 100 / 255 by reciprocal: (p + (p >> 8) + 1) >> 8
	assign duty_prod = 15'(cmd.operand) * 15'(DUTY_SCALE);
	assign duty_sum  = 16'(duty_prod) + 16'(duty_prod >> 8) + 16'd1;
	assign duty      = duty_sum[15:8];
	assign wait_ms   = 16'(cmd.operand) * 16'(cfg.wait_unit_ms);

	always_comb begin
		st_nxt = st;
		act    = ACT_NONE;
		arg    = '0;
		dur    = '0;
		nxt    = st.pc;
		if (!st.halted) begin
			if (!st.running && cmd.opcode != OP_START) begin
				nxt = pc_inc1;
			end else begin
				nxt = pc_inc2;
				case (cmd.opcode)
					OP_START: st_nxt.running = 1'b1;
					OP_WAIT: begin
						act = ACT_WAIT;
						dur = wait_ms;
					end
					OP_LED_ON:   act = ACT_LED_ON;
					OP_LED_OFF:  act = ACT_LED_OFF;
					OP_TONE: begin
						act = ACT_TONE;
						arg = cmd.operand;
					end
					OP_TONE_OFF: act = ACT_TONE_OFF;
					OP_STOP, OP_STOP_ALT: act = ACT_STOP;
					OP_FWD: begin
						act = ACT_FWD;
						arg = duty;
					end
					OP_REV: begin
						act = ACT_REV;
						arg = duty;
					end
					OP_RIGHT: begin
						act = ACT_RIGHT;
						arg = {1'b0, cfg.turn_duty};
						dur = cfg.right_turn_ms;
					end
					OP_LEFT: begin
						act = ACT_LEFT;
						arg = {1'b0, cfg.turn_duty};
						dur = cfg.left_turn_ms;
					end
					OP_LOOP_BEGIN: begin
						if (!st.in_loop) begin
							st_nxt.loop_start     = pc_inc2;
							st_nxt.loop_remaining = cmd.operand;
							st_nxt.in_loop        = 1'b1;
						end
					end
					OP_LOOP_END: begin
						if (st.loop_remaining != 8'd0) begin
							nxt                   = st.loop_start;
							st_nxt.loop_remaining = st.loop_remaining - 8'd1;
						end else begin
							st_nxt.in_loop = 1'b0;
						end
					end
					OP_END: begin
						act            = ACT_END;
						st_nxt.running = 1'b0;
						st_nxt.halted  = 1'b1;
						nxt            = st.pc;
					end
					default: nxt = pc_inc1;
				endcase
			end
			st_nxt.pc = nxt;
		end
	end

	assign rsp.action       = act;
	assign rsp.argument     = arg;
	assign rsp.duration_ms  = dur;
	assign rsp.next_address = RSP_ADDR_W'(nxt);
	assign rsp.finished     = st_nxt.halted;

endmodule

>>> rtl/robot_bytecode_sequencer_core.sv
// Robot bytecode sequencer top level: input register, decode, result register.
//
// Usage: the fetch side offers one instruction (opcode byte at the program
// counter, operand byte after it) on cmd with cmd_valid/cmd_ready. Each
// instruction yields exactly one result on rsp with rsp_valid/rsp_ready:
// the action, its argument and duration, the next fetch address and the
// finished flag. Settings are written through cfg_we/cfg_index/cfg_data
// while no transaction is in flight.
// Path: an accepted instruction waits in the input register while it is
// decoded; the result register takes its decode once that register is empty
// or its result is being taken.
// Throughput: one instruction per cycle while rsp_ready stays high; the decode
// and the next-state logic of the program counter and loop registers are
// combinational between the input register and the result register.
// Reset: the program counter, loop state and run flags clear; settings take
// their default values; both registers empty.
// Stall: while rsp_ready is low, the result holds and one more instruction
// waits in the input register; cmd_ready drops only when both are full.
module robot_bytecode_sequencer_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rbs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rbs_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          cmd_valid,
	output logic                          cmd_ready,
	input  rbs_pkg::cmd_t                 cmd,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output rbs_pkg::rsp_t                 rsp
);
	import rbs_pkg::*;

	cfg_t   cfg;
	state_t st_q;
	state_t st_nxt;
	cmd_t   cmd_s1;
	logic   valid_s1;
	rsp_t   rsp_comb;
	rsp_t   rsp_s2;
	logic   valid_s2;
	logic   adv_s1;

	rbs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rbs_exec u_exec (
		.cmd    (cmd_s1),
		.st     (st_q),
		.cfg    (cfg),
		.rsp    (rsp_comb),
		.st_nxt (st_nxt)
	);

	assign adv_s1    = valid_s1 && (!valid_s2 || rsp_ready);
	assign cmd_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			st_q     <= '0;
		end else begin
			if (cmd_ready) begin
				valid_s1 <= cmd_valid;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
				st_q     <= st_nxt;
			end else if (rsp_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ready && cmd_valid) begin
			cmd_s1 <= cmd;
		end
		if (adv_s1) begin
			rsp_s2 <= rsp_comb;
		end
	end

	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.halted |=> st_q.halted)
		else $error("halted flag cleared");

	a_halt_not_running: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.halted |-> !st_q.running)
		else $error("running while halted");

	a_halt_pc_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && st_q.halted) |=> $stable(st_q.pc))
		else $error("program counter moved after halt");

	a_loop_count_open: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.loop_remaining != 8'd0) |-> st_q.in_loop)
		else $error("loop count pending with no loop open");

	a_finished_state: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.finished) |-> st_q.halted)
		else $error("finished result without halt");

endmodule

>>> sim/tb_robot_bytecode_sequencer_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for robot_bytecode_sequencer_core: instructions in, actions checked.
module tb_robot_bytecode_sequencer_core;
	import rbs_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam logic [7:0] OP_UNASSIGNED = 8'h00;

	class seq_scoreboard;
		logic [7:0]           wait_unit;
		logic [15:0]          right_ms;
		logic [15:0]          left_ms;
		logic [6:0]           duty;
		logic [ADDR_BITS-1:0] pc;
		logic [ADDR_BITS-1:0] loop_start;
		logic [7:0]           loop_left;
		bit                   running;
		bit                   in_loop;
		bit                   halted;
		rsp_t                 expected_results[$];
		int                   mismatches;
		int                   checked;
		int                   jumps;
		int                   settings;

		function new();
			wait_unit  = RST_WAIT_UNIT;
			right_ms   = RST_RIGHT_TURN;
			left_ms    = RST_LEFT_TURN;
			duty       = RST_TURN_DUTY;
			pc         = '0;
			loop_start = '0;
			loop_left  = '0;
			running    = 1'b0;
			in_loop    = 1'b0;
			halted     = 1'b0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_WAIT_UNIT:  wait_unit = val[7:0];
				REG_RIGHT_TURN: right_ms  = val[15:0];
				REG_LEFT_TURN:  left_ms   = val[15:0];
				REG_TURN_DUTY:  duty      = val[6:0];
				default: ;
			endcase
		endfunction

		function rsp_t decode_instruction(cmd_t c);
			rsp_t                 e;
			logic [15:0]          scaled;
			logic [ADDR_BITS-1:0] nxt;
			e = '0;
			e.action = ACT_NONE;
			nxt = pc;
			scaled = 16'(c.operand) * 16'(DUTY_SCALE) / 16'd255;
			if (!halted) begin
				if (!running && c.opcode != OP_START) begin
					nxt = pc + ADDR_BITS'(1);
				end else begin
					nxt = pc + ADDR_BITS'(2);
					case (c.opcode)
						OP_START: running = 1'b1;
						OP_WAIT: begin
							e.action = ACT_WAIT;
							e.duration_ms = 16'(c.operand) * 16'(wait_unit);
						end
						OP_LED_ON:  e.action = ACT_LED_ON;
						OP_LED_OFF: e.action = ACT_LED_OFF;
						OP_TONE: begin
							e.action = ACT_TONE;
							e.argument = c.operand;
						end
						OP_TONE_OFF:          e.action = ACT_TONE_OFF;
						OP_STOP, OP_STOP_ALT: e.action = ACT_STOP;
						OP_FWD: begin
							e.action = ACT_FWD;
							e.argument = scaled[7:0];
						end
						OP_REV: begin
							e.action = ACT_REV;
							e.argument = scaled[7:0];
						end
						OP_RIGHT: begin
							e.action = ACT_RIGHT;
							e.argument = {1'b0, duty};
							e.duration_ms = right_ms;
						end
						OP_LEFT: begin
							e.action = ACT_LEFT;
							e.argument = {1'b0, duty};
							e.duration_ms = left_ms;
						end
						OP_LOOP_BEGIN: begin
							if (!in_loop) begin
								loop_start = nxt;
								loop_left = c.operand;
								in_loop = 1'b1;
							end
						end
						OP_LOOP_END: begin
							if (loop_left != 8'd0) begin
								nxt = loop_start;
								loop_left = loop_left - 8'd1;
								jumps++;
							end else begin
								in_loop = 1'b0;
							end
						end
						OP_END: begin
							e.action = ACT_END;
							running = 1'b0;
							halted = 1'b1;
							nxt = pc;
						end
						default: nxt = pc + ADDR_BITS'(1);
					endcase
				end
				pc = nxt;
			end
			e.next_address = RSP_ADDR_W'(nxt);
			e.finished = halted;
			return e;
		endfunction

		function void note_instruction(cmd_t c);
			expected_results.push_back(decode_instruction(c));
		endfunction

		function void check_result(rsp_t got);
			rsp_t e;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: act=%0d arg=%0d dur=%0d next=%h fin=%0b",
						got.action, got.argument, got.duration_ms,
						got.next_address, got.finished);
				return;
			end
			e = expected_results.pop_front();
			checked++;
			if (got.action !== e.action || got.argument !== e.argument ||
			    got.duration_ms !== e.duration_ms || got.next_address !== e.next_address ||
			    got.finished !== e.finished) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch at result %0d: exp act=%0d arg=%0d dur=%0d next=%h fin=%0b",
						checked, e.action, e.argument, e.duration_ms,
						e.next_address, e.finished);
					$display("  got act=%0d arg=%0d dur=%0d next=%h fin=%0b",
						got.action, got.argument, got.duration_ms,
						got.next_address, got.finished);
				end
			end
		endfunction

		function int pending();
			return expected_results.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  cmd_valid;
	logic                  cmd_ready;
	cmd_t                  cmd;
	logic                  rsp_valid;
	logic                  rsp_ready = 1'b0;
	rsp_t                  rsp;

	seq_scoreboard sb = new();
	bit pace;
	int instr_sent;
	int hold_left;
	int quiet;

	robot_bytecode_sequencer_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] action_op();
		logic [7:0] ops [12] = '{OP_START, OP_WAIT, OP_LED_ON, OP_LED_OFF, OP_TONE,
			OP_TONE_OFF, OP_STOP, OP_STOP_ALT, OP_FWD, OP_REV, OP_RIGHT, OP_LEFT};
		logic [7:0] op;
		if ($urandom_range(0, 99) < 15) begin
			do
				op = 8'($urandom);
			while (op == OP_END || op == OP_LOOP_BEGIN || op == OP_LOOP_END);
			return op;
		end
		return ops[$urandom_range(0, 11)];
	endfunction

	function automatic logic [7:0] any_operand();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	always @(posedge clk) begin
		if (hold_left == 0 && pace && $urandom_range(0, 3) == 0)
			hold_left = gap_len();
		if (hold_left > 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			sb.check_result(rsp);
	end

	task automatic issue(input logic [7:0] op, input logic [7:0] arg);
		cmd_t c;
		c.opcode = op;
		c.operand = arg;
		if (pace && $urandom_range(0, 1) == 1) begin
			cmd_valid <= 1'b0;
			repeat (gap_len()) @(posedge clk);
		end
		cmd <= c;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
		sb.note_instruction(c);
		instr_sent++;
	endtask

	task automatic drain_results();
		cmd_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	task automatic reconfigure(input logic [15:0] w, input logic [15:0] rt,
	                           input logic [15:0] lt, input logic [15:0] d);
		drain_results();
		repeat (4) @(posedge clk);
		put_reg(REG_WAIT_UNIT, w);
		put_reg(REG_RIGHT_TURN, rt);
		put_reg(REG_LEFT_TURN, lt);
		put_reg(REG_TURN_DUTY, d);
		cfg_we <= 1'b0;
		sb.settings++;
	endtask

	task automatic close_loop();
		while (sb.in_loop) issue(OP_LOOP_END, any_operand());
	endtask

	task automatic loop_block();
		int r;
		int reps;
		int body;
		r = $urandom_range(0, 99);
		if (r < 85)
			reps = $urandom_range(0, 3);
		else if (r < 95)
			reps = $urandom_range(4, 20);
		else
			reps = 255;
		body = (reps > 20) ? 0 : $urandom_range(1, 4);
		issue(OP_LOOP_BEGIN, 8'(reps));
		repeat (reps + 1) begin
			repeat (body) issue(action_op(), any_operand());
			issue(OP_LOOP_END, any_operand());
		end
	endtask

	initial begin
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
		$display("tb_robot_bytecode_sequencer_core: FAIL");
		$finish;
	end

	initial begin
		int phase;
		int target;
		int r;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_WAIT_UNIT;
		cfg_data = '0;
		cmd_valid = 1'b0;
		cmd = '0;
		pace = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		pace = 1'b1;
		issue(OP_UNASSIGNED, 8'h00);
		issue(OP_END, 8'hFF);
		issue(OP_LOOP_END, 8'h80);
		issue(OP_START, 8'h00);
		issue(OP_START, 8'h55);
		issue(OP_WAIT, 8'hFF);
		issue(OP_WAIT, 8'h00);
		issue(OP_LED_ON, 8'h00);
		issue(OP_LED_OFF, 8'hFF);
		issue(OP_TONE, 8'hFF);
		issue(OP_TONE, 8'h00);
		issue(OP_TONE_OFF, 8'h00);
		issue(OP_STOP, 8'h00);
		issue(OP_STOP_ALT, 8'hFF);
		issue(OP_FWD, 8'hFF);
		issue(OP_FWD, 8'h01);
		issue(OP_REV, 8'h80);
		issue(OP_REV, 8'h00);
		issue(OP_RIGHT, 8'h00);
		issue(OP_LEFT, 8'hFF);
		issue(OP_UNASSIGNED, 8'hAA);
		issue(OP_LOOP_END, 8'h00);
		issue(OP_LOOP_BEGIN, 8'h02);
		issue(OP_LOOP_BEGIN, 8'h07);
		issue(OP_LED_ON, 8'h00);
		repeat (3) issue(OP_LOOP_END, 8'h00);
		drain_results();

		for (phase = 0; phase < 5; phase++) begin
			case (phase)
				1: reconfigure(16'd1, 16'd0, 16'd0, 16'd0);
				2: reconfigure(16'd255, 16'hFFFF, 16'hFFFF, 16'd100);
				3: reconfigure(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
				4: reconfigure(16'($urandom_range(1, 255)), 16'($urandom), 16'($urandom),
					16'($urandom_range(0, 100)));
				default: ;
			endcase
			pace = (phase != 2);
			target = instr_sent + 210;
			while (instr_sent < target) begin
				r = $urandom_range(0, 99);
				if (r < 35) begin
					close_loop();
					loop_block();
				end else if (r < 90) begin
					issue(action_op(), any_operand());
				end else if (r < 94) begin
					issue(OP_LOOP_BEGIN, any_operand());
				end else if (r < 98) begin
					issue(OP_LOOP_END, any_operand());
				end else begin
					drain_results();
				end
			end
		end

		pace = 1'b1;
		close_loop();

		issue(OP_END, any_operand());
		issue(OP_START, 8'h00);
		issue(OP_WAIT, 8'hFF);
		issue(OP_LOOP_BEGIN, 8'h03);
		drain_results();
		repeat (8) @(posedge clk);

		$display("covered %0d instructions over %0d register settings and %0d loop jumps,",
			sb.checked, sb.settings + 1, sb.jumps);
		$display("including idle stepping, receiver stalls and execution after halt");
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("tb_robot_bytecode_sequencer_core: PASS");
		else
			$display("tb_robot_bytecode_sequencer_core: FAIL");
		$finish;
	end

endmodule

>>> files.f
rtl/rbs_pkg.sv
rtl/rbs_cfg.sv
rtl/rbs_exec.sv
rtl/robot_bytecode_sequencer_core.sv
sim/tb_robot_bytecode_sequencer_core.sv
